@@ hw/rtl/bse_pkg.sv @@
package bse_pkg;

  localparam int DATA_W = 32;

  // One entry of the queue between the front and back parts
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic                     drop;
  } bse_item_t;

endpackage

@@ hw/rtl/bse_front.sv @@
module bse_front import bse_pkg::*; #(
  parameter int MAX_ITEMS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic                     in_last,
  output logic                     push_valid,
  input  logic                     push_ready,
  output bse_item_t                push_item
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             full;
  logic             xfer;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign xfer       = in_valid && push_ready;
  assign full       = (cnt_r == CNT_W'(MAX_ITEMS));

  // Tag each element: kept while the store has room, dropped once it is full
  always_comb begin
    push_item.value = in_value;
    push_item.last  = in_last;
    push_item.drop  = full;
  end

  // Track the fill level of the current list
  always_comb begin
    cnt_nxt = cnt_r;
    if (xfer) begin
      if (in_last) begin
        cnt_nxt = '0;
      end else if (!full) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ hw/rtl/bse_fifo.sv @@
module bse_fifo import bse_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  bse_item_t push_item,
  output logic      pop_valid,
  input  logic      pop_ready,
  output bse_item_t pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bse_item_t        slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             do_push, do_pop;

  assign push_ready = (fill_r != CNT_W'(DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_item   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Hold queued entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ hw/rtl/bse_back.sv @@
module bse_back import bse_pkg::*; #(
  parameter int MAX_ITEMS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     pop_valid,
  output logic                     pop_ready,
  input  bse_item_t                pop_item,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_sorted_value,
  output logic                     out_final_res,
  output logic                     out_overflow
);

  localparam int AW    = $clog2(MAX_ITEMS);
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PASS_RD0,
    ST_PASS_CARRY,
    ST_PASS_CMP,
    ST_PASS_END,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } state_t;

  // Element store: one write and one registered read per cycle
  logic signed [DATA_W-1:0] mem [MAX_ITEMS];
  logic signed [DATA_W-1:0] rd_data_r;
  logic [AW-1:0]            rd_addr;
  logic                     we;
  logic [AW-1:0]            wa;
  logic signed [DATA_W-1:0] wd;

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [CNT_W-1:0]         len_r, len_nxt;
  logic [AW-1:0]            idx_r, idx_nxt;
  logic [AW-1:0]            k_r, k_nxt;
  logic signed [DATA_W-1:0] carry_r, carry_nxt;
  logic                     swapped_r, swapped_nxt;
  logic                     dropped_r, dropped_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_value_r, out_value_nxt;
  logic                     out_final_r, out_final_nxt;
  logic                     out_ovf_r, out_ovf_nxt;

  logic [CNT_W-1:0]         list_len;
  logic [CNT_W-1:0]         idx_ext;
  logic                     gt;

  assign pop_ready        = (state_r == ST_LOAD);
  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_value_r;
  assign out_final_res    = out_final_r;
  assign out_overflow     = out_ovf_r;

  assign idx_ext  = CNT_W'(idx_r);
  assign gt       = (carry_r > rd_data_r);
  assign list_len = pop_item.drop ? cnt_r : cnt_r + CNT_W'(1);

  // Sequencer: load the list, run shrinking bubble passes, then drain
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    carry_nxt     = carry_r;
    swapped_nxt   = swapped_r;
    dropped_nxt   = dropped_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_final_nxt = out_final_r;
    out_ovf_nxt   = out_ovf_r;
    rd_addr       = '0;
    we            = 1'b0;
    wa            = '0;
    wd            = carry_r;

    unique case (state_r)
      ST_LOAD: begin
        if (pop_valid) begin
          dropped_nxt = dropped_r | pop_item.drop;
          if (!pop_item.drop) begin
            we      = 1'b1;
            wa      = cnt_r[AW-1:0];
            wd      = pop_item.value;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          if (pop_item.last) begin
            cnt_nxt   = list_len;
            len_nxt   = list_len;
            k_nxt     = '0;
            state_nxt = (list_len > CNT_W'(1)) ? ST_PASS_RD0 : ST_EMIT_RD;
          end
        end
      end

      ST_PASS_RD0: begin
        rd_addr     = '0;
        idx_nxt     = '0;
        swapped_nxt = 1'b0;
        state_nxt   = ST_PASS_CARRY;
      end

      ST_PASS_CARRY: begin
        carry_nxt = rd_data_r;
        rd_addr   = AW'(1);
        state_nxt = ST_PASS_CMP;
      end

      // Keep the larger element travelling, write back the smaller one
      ST_PASS_CMP: begin
        we          = 1'b1;
        wa          = idx_r;
        wd          = gt ? rd_data_r : carry_r;
        carry_nxt   = gt ? carry_r : rd_data_r;
        swapped_nxt = swapped_r | gt;
        if ((idx_ext + CNT_W'(2)) < len_r) begin
          rd_addr = AW'(idx_ext + CNT_W'(2));
          idx_nxt = idx_r + AW'(1);
        end else begin
          state_nxt = ST_PASS_END;
        end
      end

      ST_PASS_END: begin
        we      = 1'b1;
        wa      = AW'(len_r - CNT_W'(1));
        wd      = carry_r;
        len_nxt = len_r - CNT_W'(1);
        k_nxt   = '0;
        if (swapped_r && (len_r - CNT_W'(1)) > CNT_W'(1)) begin
          state_nxt = ST_PASS_RD0;
        end else begin
          state_nxt = ST_EMIT_RD;
        end
      end

      ST_EMIT_RD: begin
        rd_addr   = k_r;
        state_nxt = ST_EMIT_LD;
      end

      ST_EMIT_LD: begin
        out_valid_nxt = 1'b1;
        out_value_nxt = rd_data_r;
        out_final_nxt = ((CNT_W'(k_r) + CNT_W'(1)) == cnt_r);
        out_ovf_nxt   = dropped_r;
        state_nxt     = ST_EMIT_WAIT;
      end

      // Hold the result until its transfer, then move on or start a new list
      ST_EMIT_WAIT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_final_r) begin
            cnt_nxt     = '0;
            dropped_nxt = 1'b0;
            state_nxt   = ST_LOAD;
          end else begin
            k_nxt     = k_r + AW'(1);
            state_nxt = ST_EMIT_RD;
          end
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
    len_r       <= len_nxt;
    idx_r       <= idx_nxt;
    k_r         <= k_nxt;
    carry_r     <= carry_nxt;
    swapped_r   <= swapped_nxt;
    out_value_r <= out_value_nxt;
    out_final_r <= out_final_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  // Element store write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

@@ hw/rtl/bubble_sort_engine_top.sv @@
// Bubble sort engine.
// Input channel (in_valid/in_ready, in_value, in_last) takes one signed
// 32-bit element per transfer; in_last closes the list. Up to MAX_ITEMS
// elements are kept, later ones are dropped and every result of that list
// then carries out_overflow.
// Result channel (out_valid/out_ready) returns the list in ascending order,
// one element per transfer, with out_final_res on the last one.
// For a list of n stored elements: loading takes one element per cycle while
// the input queue holds entries; bubble passes then run over len elements,
// len falling by one per pass, at most n - 1 passes, fewer once a pass makes
// no swap; each result is then read, registered and held until taken. The
// single write port of the store sets the one-compare-per-cycle pass rate.
// A four-entry queue keeps taking input while a list is sorted or drained.
// A stalled receiver holds the result register and the sorter; input stops
// only once the queue fills.
// Reset (rst_n low, synchronous) empties the queue and returns to loading;
// no clearing pass is needed.
module bubble_sort_engine_top import bse_pkg::*; #(
  parameter int MAX_ITEMS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic                     in_last,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_sorted_value,
  output logic                     out_final_res,
  output logic                     out_overflow
);

  logic      push_valid, push_ready;
  bse_item_t push_item;
  logic      pop_valid, pop_ready;
  bse_item_t pop_item;

  bse_front #(.MAX_ITEMS(MAX_ITEMS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_value   (in_value),
    .in_last    (in_last),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  bse_fifo #(.DEPTH(4)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  bse_back #(.MAX_ITEMS(MAX_ITEMS)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .pop_valid        (pop_valid),
    .pop_ready        (pop_ready),
    .pop_item         (pop_item),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sorted_value (out_sorted_value),
    .out_final_res    (out_final_res),
    .out_overflow     (out_overflow)
  );

endmodule

@@ hw/rtl/bse_checker.sv @@
module bse_checker import bse_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     in_last,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [DATA_W-1:0] out_sorted_value,
  input logic                     out_final_res,
  input logic                     out_overflow
);

  logic                     in_xfer, out_xfer;
  logic                     have_prev_r;
  logic signed [DATA_W-1:0] prev_value_r;
  logic                     prev_ovf_r;
  logic [3:0]               lists_r;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // Remember the previous result of the list being drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
    end else if (out_xfer) begin
      have_prev_r <= !out_final_res;
    end
    if (out_xfer) begin
      prev_value_r <= out_sorted_value;
      prev_ovf_r   <= out_overflow;
    end
  end

  // Count lists closed at the input but not yet fully drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lists_r <= '0;
    end else begin
      lists_r <= lists_r + 4'(in_xfer && in_last) - 4'(out_xfer && out_final_res);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sorted_value))
    else $error("result dropped or changed while stalled");

  a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && have_prev_r |-> out_sorted_value >= prev_value_r)
    else $error("results not in ascending order");

  a_ovf_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && have_prev_r |-> out_overflow == prev_ovf_r)
    else $error("overflow flag changed within a list");

  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> lists_r != '0)
    else $error("result shown before its list was closed");

endmodule

bind bubble_sort_engine_top bse_checker u_bse_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_last          (in_last),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_sorted_value (out_sorted_value),
  .out_final_res    (out_final_res),
  .out_overflow     (out_overflow)
);
